[hdl/color_planes_to_scalar_pixel_core_defines.svh]
// Assertion macros shared by the color plane reducer RTL.
`ifndef COLOR_PLANES_TO_SCALAR_PIXEL_CORE_DEFINES_SVH
`define COLOR_PLANES_TO_SCALAR_PIXEL_CORE_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define CPSP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define CPSP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/cpsp_pkg.sv]
// Shared constants, codes and payload types of the color plane reducer.
`timescale 1ns / 1ps
package cpsp_pkg;

    // Sample format and plane limits
    localparam int SAMPLE_BITS = 16;
    localparam int PLANES      = 4;
    localparam int CNT_BITS    = 3;
    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PLANES   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PICK     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HSV_PART = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_0 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_1 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_2 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_3 = 3'd7;

    // Reduction modes
    localparam logic [2:0] MODE_PICK     = 3'd0;
    localparam logic [2:0] MODE_LUMA     = 3'd1;
    localparam logic [2:0] MODE_WEIGHTED = 3'd2;
    localparam logic [2:0] MODE_MEAN     = 3'd3;
    localparam logic [2:0] MODE_MAX      = 3'd4;
    localparam logic [2:0] MODE_MIN      = 3'd5;
    localparam logic [2:0] MODE_HSV      = 3'd6;
    localparam logic [2:0] MODE_RSVD     = 3'd7;

    // HSV component select
    localparam logic [1:0] HSV_VALUE = 2'd0;
    localparam logic [1:0] HSV_SAT   = 2'd1;

    // Status codes
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_FEW      = 2'd1;
    localparam logic [1:0] STAT_PICK_OOR = 2'd2;

    // Rec.709 luminance coefficients, Q0.16
    localparam logic [15:0] LUMA_R = 16'd13933;
    localparam logic [15:0] LUMA_G = 16'd46871;
    localparam logic [15:0] LUMA_B = 16'd4732;

    // Hue in degrees Q9.6
    localparam logic signed [17:0] HUE_GREEN = 18'sd7680;
    localparam logic signed [17:0] HUE_BLUE  = 18'sd15360;
    localparam logic signed [17:0] HUE_FULL  = 18'sd23040;

    // Shared divider geometry
    localparam int QUOT_BITS = 17;
    localparam int NUM_BITS  = 33;
    localparam int DEN_BITS  = 17;

    // Channel payloads
    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sample_0;
        logic [SAMPLE_BITS-1:0] sample_1;
        logic [SAMPLE_BITS-1:0] sample_2;
        logic [SAMPLE_BITS-1:0] sample_3;
    } t_in_data;

    typedef struct packed {
        logic signed [31:0] scalar_value;
        logic [1:0]         status;
    } t_out_data;

endpackage

[hdl/color_planes_to_scalar_pixel_core.sv]
// Color plane to scalar pixel reducer: config registers, pipeline, output skid.
// Throughput: one pixel per cycle while o_in_stall is low; the 17-step restoring
// divider (one quotient bit per stage) sets the pipeline depth, not the rate.
// Reset (synchronous, i_rst_n low) clears all valid bits and loads the
// register defaults: mode luminance, three planes, pick plane 0, HSV part value, weights 0.
`timescale 1ns / 1ps
`include "color_planes_to_scalar_pixel_core_defines.svh"

module color_planes_to_scalar_pixel_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [cpsp_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [cpsp_pkg::CFG_W-1:0]        i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  cpsp_pkg::t_in_data                i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output cpsp_pkg::t_out_data               o_out_data
);

    localparam int SB    = cpsp_pkg::SAMPLE_BITS;
    localparam int NP    = cpsp_pkg::PLANES;
    localparam int QB    = cpsp_pkg::QUOT_BITS;
    localparam int NB    = cpsp_pkg::NUM_BITS;
    localparam int DB    = cpsp_pkg::DEN_BITS;
    localparam int ST_C  = 3;
    localparam int NSTG  = ST_C + QB + 1;
    localparam int LAST  = NSTG - 1;

    localparam logic [1:0] SEC_RED   = 2'd0;
    localparam logic [1:0] SEC_GREEN = 2'd1;
    localparam logic [1:0] SEC_BLUE  = 2'd2;

    typedef struct packed {
        logic [1:0]         status;
        logic               use_div;
        logic               neg;
        logic               is_hue;
        logic [1:0]         sector;
        logic signed [31:0] direct;
    } t_side;

    // ---------------- configuration registers ----------------
    logic [2:0]                       r_mode;
    logic [cpsp_pkg::CNT_BITS-1:0]    r_plane_cnt;
    logic [1:0]                       r_pick;
    logic [1:0]                       r_hsv_part;
    logic signed [15:0]               r_weight [NP];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= cpsp_pkg::MODE_LUMA;
            r_plane_cnt <= 3'd3;
            r_pick      <= 2'd0;
            r_hsv_part  <= cpsp_pkg::HSV_VALUE;
            for (int i = 0; i < NP; i++) r_weight[i] <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                cpsp_pkg::REG_MODE:     r_mode      <= i_cfg_data[2:0];
                cpsp_pkg::REG_PLANES:   r_plane_cnt <= i_cfg_data[2:0];
                cpsp_pkg::REG_PICK:     r_pick      <= i_cfg_data[1:0];
                cpsp_pkg::REG_HSV_PART: r_hsv_part  <= i_cfg_data[1:0];
                cpsp_pkg::REG_WEIGHT_0: r_weight[0] <= i_cfg_data;
                cpsp_pkg::REG_WEIGHT_1: r_weight[1] <= i_cfg_data;
                cpsp_pkg::REG_WEIGHT_2: r_weight[2] <= i_cfg_data;
                cpsp_pkg::REG_WEIGHT_3: r_weight[3] <= i_cfg_data;
            endcase
        end
    end

    // Plane count clamped to the sample fields
    logic [2:0] cnt;
    assign cnt = (r_plane_cnt > 3'(NP)) ? 3'(NP) : r_plane_cnt;

    // ---------------- pipeline control ----------------
    // Whole pipeline moves together; the skid stage catches one result.
    logic            en;
    logic [NSTG-1:0] r_vld;
    logic            r_out_vld;
    logic            r_skid_vld;
    cpsp_pkg::t_out_data r_out;
    cpsp_pkg::t_out_data r_skid;
    cpsp_pkg::t_out_data fin;

    assign en          = !r_skid_vld;
    assign o_in_stall  = r_skid_vld;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NSTG-2:0], i_in_valid};
        end
    end

    // ---------------- stage I: input register ----------------
    logic [SB-1:0] r_i_smp [NP];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_i_smp[0] <= i_in_data.sample_0;
            r_i_smp[1] <= i_in_data.sample_1;
            r_i_smp[2] <= i_in_data.sample_2;
            r_i_smp[3] <= i_in_data.sample_3;
        end
    end

    // ---------------- stage A: products, extremes, status ----------------
    logic [1:0]         a_stat;
    logic [SB-1:0]      a_sel, a_mx, a_mn;
    logic [SB+1:0]      a_sum;
    logic [1:0]         a_sec;
    logic signed [SB:0] a_diff;
    logic signed [SB+16:0] a_wp [NP];

    logic [1:0]         r_a_stat;
    logic [SB-1:0]      r_a_sel, r_a_mx, r_a_mn;
    logic [SB+1:0]      r_a_sum;
    logic [1:0]         r_a_sec;
    logic signed [SB:0] r_a_diff;
    logic [31:0]        r_a_lr, r_a_lg, r_a_lb;
    logic signed [SB+16:0] r_a_wp [NP];

    always_comb begin
        logic [SB-1:0] s0, s1, s2;
        s0 = r_i_smp[0];
        s1 = r_i_smp[1];
        s2 = r_i_smp[2];

        // configuration checks
        if (cnt == 3'd0 || r_mode == cpsp_pkg::MODE_RSVD) begin
            a_stat = cpsp_pkg::STAT_FEW;
        end else if ((r_mode == cpsp_pkg::MODE_LUMA || r_mode == cpsp_pkg::MODE_HSV)
                     && cnt < 3'd3) begin
            a_stat = cpsp_pkg::STAT_FEW;
        end else if (r_mode == cpsp_pkg::MODE_PICK && {1'b0, r_pick} >= cnt) begin
            a_stat = cpsp_pkg::STAT_PICK_OOR;
        end else begin
            a_stat = cpsp_pkg::STAT_OK;
        end

        // pick, max or min over the planes in use; and the plain sum
        a_sel = r_i_smp[0];
        a_sum = {2'b00, r_i_smp[0]};
        for (int i = 1; i < NP; i++) begin
            if (3'(i) < cnt) begin
                a_sum = a_sum + {2'b00, r_i_smp[i]};
                if (r_mode == cpsp_pkg::MODE_MAX ? (r_i_smp[i] > a_sel)
                                                 : (r_i_smp[i] < a_sel)) begin
                    a_sel = r_i_smp[i];
                end
            end
        end
        if (r_mode == cpsp_pkg::MODE_PICK) a_sel = r_i_smp[r_pick];

        // weighted products, zero beyond the plane count
        for (int i = 0; i < NP; i++) begin
            if (3'(i) < cnt)
                a_wp[i] = r_weight[i] * $signed({1'b0, r_i_smp[i]});
            else
                a_wp[i] = '0;
        end

        // HSV extremes over red, green, blue; ties go red, then green
        a_mx = s0;
        a_mn = s0;
        if (s1 > a_mx) a_mx = s1;
        if (s2 > a_mx) a_mx = s2;
        if (s1 < a_mn) a_mn = s1;
        if (s2 < a_mn) a_mn = s2;
        if (a_mx == s0) begin
            a_sec  = SEC_RED;
            a_diff = $signed({1'b0, s1}) - $signed({1'b0, s2});
        end else if (a_mx == s1) begin
            a_sec  = SEC_GREEN;
            a_diff = $signed({1'b0, s2}) - $signed({1'b0, s0});
        end else begin
            a_sec  = SEC_BLUE;
            a_diff = $signed({1'b0, s0}) - $signed({1'b0, s1});
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_stat <= a_stat;
            r_a_sel  <= a_sel;
            r_a_sum  <= a_sum;
            r_a_mx   <= a_mx;
            r_a_mn   <= a_mn;
            r_a_sec  <= a_sec;
            r_a_diff <= a_diff;
            r_a_lr   <= r_i_smp[0] * cpsp_pkg::LUMA_R;
            r_a_lg   <= r_i_smp[1] * cpsp_pkg::LUMA_G;
            r_a_lb   <= r_i_smp[2] * cpsp_pkg::LUMA_B;
            for (int i = 0; i < NP; i++) r_a_wp[i] <= a_wp[i];
        end
    end

    // ---------------- stage B: sums and hue numerator ----------------
    logic [32:0]           b_luma_sum;
    logic signed [SB+18:0] b_wacc;
    logic signed [30:0]    b_dx;
    logic signed [30:0]    b_t;

    logic [1:0]            r_b_stat;
    logic [SB-1:0]         r_b_sel, r_b_mx, r_b_d;
    logic [SB+1:0]         r_b_mnum;
    logic [SB:0]           r_b_luma;
    logic signed [SB+6:0]  r_b_wsum;
    logic signed [30:0]    r_b_t;
    logic [1:0]            r_b_sec;

    always_comb begin
        b_luma_sum = {1'b0, r_a_lr} + {1'b0, r_a_lg} + {1'b0, r_a_lb} + 33'd32768;
        b_wacc = 35'sd2048;
        for (int i = 0; i < NP; i++) b_wacc = b_wacc + 35'(r_a_wp[i]);
        // 2 * 3840 * diff + d
        b_dx = {{14{r_a_diff[SB]}}, r_a_diff};
        b_t  = (b_dx <<< 13) - (b_dx <<< 9) + $signed({15'd0, r_a_mx - r_a_mn});
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_stat <= r_a_stat;
            r_b_sel  <= r_a_sel;
            r_b_mx   <= r_a_mx;
            r_b_d    <= r_a_mx - r_a_mn;
            r_b_mnum <= r_a_sum + {16'd0, cnt[2:1]};
            r_b_luma <= b_luma_sum[32:16];
            r_b_wsum <= b_wacc[SB+18:12];
            r_b_t    <= b_t;
            r_b_sec  <= r_a_sec;
        end
    end

    // ---------------- stage C: result select and divider setup ----------------
    t_side            c_side;
    logic [NB-1:0]    c_num;
    logic [DB-1:0]    c_den;
    logic [NB-1:0]    c_negnum;

    always_comb begin
        c_side.status  = r_b_stat;
        c_side.use_div = 1'b0;
        c_side.neg     = 1'b0;
        c_side.is_hue  = 1'b0;
        c_side.sector  = r_b_sec;
        c_side.direct  = '0;
        c_num          = '0;
        c_den          = '0;
        // 2d - 1 + |t| for a negative hue numerator
        c_negnum = {16'd0, r_b_d, 1'b0} - {{NB-1{1'b0}}, 1'b1} - NB'(r_b_t);
        unique case (r_mode)
            cpsp_pkg::MODE_PICK, cpsp_pkg::MODE_MAX, cpsp_pkg::MODE_MIN: begin
                c_side.direct = {16'd0, r_b_sel};
            end
            cpsp_pkg::MODE_LUMA: begin
                c_side.direct = {15'd0, r_b_luma};
            end
            cpsp_pkg::MODE_WEIGHTED: begin
                c_side.direct = {{9{r_b_wsum[SB+6]}}, r_b_wsum};
            end
            cpsp_pkg::MODE_MEAN: begin
                c_side.use_div = 1'b1;
                c_num          = {15'd0, r_b_mnum};
                c_den          = {14'd0, cnt};
            end
            cpsp_pkg::MODE_HSV: begin
                if (r_hsv_part == cpsp_pkg::HSV_VALUE) begin
                    c_side.direct = {16'd0, r_b_mx};
                end else if (r_hsv_part == cpsp_pkg::HSV_SAT) begin
                    // (d << 16 + mx / 2) / mx, zero for a black pixel
                    c_side.use_div = (r_b_mx != '0);
                    c_num          = {1'b0, r_b_d, 1'b0, r_b_mx[SB-1:1]};
                    c_den          = {1'b0, r_b_mx};
                end else begin
                    // hue, zero for a gray pixel
                    c_side.use_div = (r_b_d != '0);
                    c_side.is_hue  = 1'b1;
                    c_side.neg     = r_b_t[30];
                    c_num          = r_b_t[30] ? c_negnum : {2'b00, r_b_t};
                    c_den          = {r_b_d, 1'b0};
                end
            end
            default: begin
                c_side.direct = '0;
            end
        endcase
        if (r_b_stat != cpsp_pkg::STAT_OK) begin
            c_side.use_div = 1'b0;
            c_side.direct  = '0;
        end
    end

    // ---------------- divider: one quotient bit per stage ----------------
    // Entry 0 is stage C; entries 1..QB are the restoring steps.
    logic [DB-1:0] r_rem [QB+1];
    logic [QB-1:0] r_lo  [QB+1];
    logic [QB-1:0] r_q   [QB+1];
    logic [DB-1:0] r_den [QB+1];
    t_side         r_side[QB+1];

    logic [DB-1:0] d_rem [QB+1];
    logic [QB-1:0] d_q   [QB+1];

    always_comb begin
        logic [DB:0] trial;
        d_rem[0] = '0;
        d_q[0]   = '0;
        for (int k = 1; k <= QB; k++) begin
            trial = {r_rem[k-1], r_lo[k-1][QB-1]};
            if (trial >= {1'b0, r_den[k-1]}) begin
                d_rem[k] = DB'(trial - {1'b0, r_den[k-1]});
                d_q[k]   = {r_q[k-1][QB-2:0], 1'b1};
            end else begin
                d_rem[k] = trial[DB-1:0];
                d_q[k]   = {r_q[k-1][QB-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rem[0]  <= {1'b0, c_num[NB-1:QB]};
            r_lo[0]   <= c_num[QB-1:0];
            r_q[0]    <= '0;
            r_den[0]  <= c_den;
            r_side[0] <= c_side;
            for (int k = 1; k <= QB; k++) begin
                r_rem[k]  <= d_rem[k];
                r_lo[k]   <= {r_lo[k-1][QB-2:0], 1'b0};
                r_q[k]    <= d_q[k];
                r_den[k]  <= r_den[k-1];
                r_side[k] <= r_side[k-1];
            end
        end
    end

    // ---------------- final result ----------------
    always_comb begin
        logic signed [17:0] qs;
        logic signed [17:0] h;
        logic signed [17:0] off;
        qs = r_side[QB].neg ? -$signed({1'b0, r_q[QB]}) : $signed({1'b0, r_q[QB]});
        unique case (r_side[QB].sector)
            SEC_GREEN: off = cpsp_pkg::HUE_GREEN;
            SEC_BLUE:  off = cpsp_pkg::HUE_BLUE;
            default:   off = '0;
        endcase
        h = off + qs;
        if (h < 0) h = h + cpsp_pkg::HUE_FULL;
        fin.status = r_side[QB].status;
        if (!r_side[QB].use_div)
            fin.scalar_value = r_side[QB].direct;
        else if (r_side[QB].is_hue)
            fin.scalar_value = {{14{h[17]}}, h};
        else
            fin.scalar_value = {15'd0, r_q[QB]};
    end

    // ---------------- output register and skid ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (!i_out_stall) begin
                r_out      <= r_skid;
                r_skid_vld <= 1'b0;
            end
        end else if (r_vld[LAST]) begin
            if (!r_out_vld || !i_out_stall) begin
                r_out     <= fin;
                r_out_vld <= 1'b1;
            end else begin
                r_skid     <= fin;
                r_skid_vld <= 1'b1;
            end
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    // ---------------- assertions ----------------
    `CPSP_ASSERT_NOW(a_skid_behind_out, r_skid_vld, r_out_vld,
        "skid stage holds a result while the output register is empty")
    `CPSP_ASSERT_NOW(a_err_zero, o_out_valid && o_out_data.status != cpsp_pkg::STAT_OK,
        o_out_data.scalar_value == 0, "error result with a nonzero value")
    `CPSP_ASSERT_NEXT(a_accept_enters, i_in_valid && !o_in_stall, r_vld[0],
        "accepted request did not enter the input stage")

endmodule

[tb/reduced_pixel_checker.sv]
// Scoreboard for the color plane reducer: predicts each pixel's result and compares it.
`timescale 1ns / 1ps

module reduced_pixel_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [cpsp_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [cpsp_pkg::CFG_W-1:0]        i_cfg_data,
    input  logic                              i_in_valid,
    input  logic                              i_in_stall,
    input  cpsp_pkg::t_in_data                i_in_data,
    input  logic                              i_out_valid,
    input  logic                              i_out_stall,
    input  cpsp_pkg::t_out_data               i_out_data,
    output int                                o_mismatches,
    output int                                o_outstanding
);
    import cpsp_pkg::*;

    // 60 degrees in Q9.6
    localparam longint HUE_STEP = 3840;
    localparam int     REPORT_MAX = 10;

    // Shadow copy of the configuration registers
    logic [2:0]         cur_mode;
    logic [2:0]         cur_planes;
    logic [1:0]         cur_pick;
    logic [1:0]         cur_part;
    logic signed [15:0] cur_weight [4];

    t_out_data expected_results [$];
    int        mismatch_count = 0;

    assign o_mismatches = mismatch_count;

    // Division rounding toward minus infinity, positive divisor
    function automatic longint floor_quot(input longint num, input longint den);
        if (num >= 0)
            return num / den;
        return -((-num + den - 1) / den);
    endfunction

    // Value, saturation or hue of the first three planes
    function automatic longint hsv_component(input longint r, input longint g,
                                             input longint b);
        longint mx, mn, d, h;
        mx = r;
        mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        d = mx - mn;
        if (cur_part == HSV_VALUE)
            return mx;
        if (cur_part == HSV_SAT)
            return (mx == 0) ? 0 : ((d <<< SAMPLE_BITS) + mx / 2) / mx;
        // hue; the reserved part select also lands here
        if (d == 0)
            return 0;
        if (mx == r)
            h = floor_quot(2 * HUE_STEP * (g - b) + d, 2 * d);
        else if (mx == g)
            h = longint'(HUE_GREEN) + floor_quot(2 * HUE_STEP * (b - r) + d, 2 * d);
        else
            h = longint'(HUE_BLUE) + floor_quot(2 * HUE_STEP * (r - g) + d, 2 * d);
        if (h < 0)
            h += longint'(HUE_FULL);
        return h;
    endfunction

    // Expected result of one pixel under the current settings
    function automatic t_out_data reduce_pixel(input t_in_data px);
        t_out_data res;
        longint    s [4];
        longint    v, acc;
        int        cnt;
        logic [1:0] st;
        s[0] = px.sample_0;
        s[1] = px.sample_1;
        s[2] = px.sample_2;
        s[3] = px.sample_3;
        cnt = (cur_planes > PLANES) ? PLANES : cur_planes;
        v   = 0;
        st  = STAT_OK;
        if (cnt == 0 || cur_mode == MODE_RSVD) begin
            st = STAT_FEW;
        end else if ((cur_mode == MODE_LUMA || cur_mode == MODE_HSV) && cnt < 3) begin
            st = STAT_FEW;
        end else begin
            case (cur_mode)
                MODE_PICK: begin
                    if (cur_pick >= cnt)
                        st = STAT_PICK_OOR;
                    else
                        v = s[cur_pick];
                end
                MODE_LUMA: begin
                    v = (s[0] * longint'(LUMA_R) + s[1] * longint'(LUMA_G) +
                         s[2] * longint'(LUMA_B) + 32768) >>> 16;
                end
                MODE_WEIGHTED: begin
                    acc = 0;
                    for (int i = 0; i < cnt; i++)
                        acc += longint'(cur_weight[i]) * s[i];
                    v = (acc + 2048) >>> 12;
                end
                MODE_MEAN: begin
                    acc = 0;
                    for (int i = 0; i < cnt; i++)
                        acc += s[i];
                    v = (acc + cnt / 2) / cnt;
                end
                MODE_MAX, MODE_MIN: begin
                    v = s[0];
                    for (int i = 1; i < cnt; i++) begin
                        if (cur_mode == MODE_MAX ? s[i] > v : s[i] < v)
                            v = s[i];
                    end
                end
                default: v = hsv_component(s[0], s[1], s[2]);
            endcase
        end
        if (st != STAT_OK)
            v = 0;
        // clamp to 32 bits signed
        if (v > 64'sd2147483647)
            v = 64'sd2147483647;
        else if (v < -64'sd2147483648)
            v = -64'sd2147483648;
        res.scalar_value = v[31:0];
        res.status       = st;
        return res;
    endfunction

    // Track register writes, queue predictions, check results
    always @(posedge i_clk) begin : watch
        t_out_data want;
        if (!i_rst_n) begin
            cur_mode   = MODE_LUMA;
            cur_planes = 3'd3;
            cur_pick   = 2'd0;
            cur_part   = HSV_VALUE;
            for (int i = 0; i < 4; i++)
                cur_weight[i] = '0;
            expected_results.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_MODE:     cur_mode      = i_cfg_data[2:0];
                    REG_PLANES:   cur_planes    = i_cfg_data[2:0];
                    REG_PICK:     cur_pick      = i_cfg_data[1:0];
                    REG_HSV_PART: cur_part      = i_cfg_data[1:0];
                    REG_WEIGHT_0: cur_weight[0] = i_cfg_data;
                    REG_WEIGHT_1: cur_weight[1] = i_cfg_data;
                    REG_WEIGHT_2: cur_weight[2] = i_cfg_data;
                    REG_WEIGHT_3: cur_weight[3] = i_cfg_data;
                    default: ;
                endcase
            end

            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                        $display("%0t: result with no pixel pending: value %0d status %0d",
                                 $realtime, i_out_data.scalar_value, i_out_data.status);
                end else begin
                    want = expected_results.pop_front();
                    if (i_out_data.scalar_value !== want.scalar_value ||
                        i_out_data.status !== want.status) begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_MAX)
                            $display("%0t: mismatch: expected %0d/%0d, got %0d/%0d",
                                     $realtime, want.scalar_value, want.status,
                                     i_out_data.scalar_value, i_out_data.status);
                    end
                end
            end

            if (i_in_valid && !i_in_stall)
                expected_results.push_back(reduce_pixel(i_in_data));
        end
        o_outstanding <= expected_results.size();
    end

endmodule

[tb/tb_top.sv]
// Testbench top for the color plane reducer: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;
    import cpsp_pkg::*;

    localparam logic [1:0] HSV_HUE       = 2'd2;
    localparam logic [1:0] HSV_PART_RSVD = 2'd3;
    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASES         = 16;
    localparam int PHASE_ITEMS    = 50;
    localparam int PRESS_ITEMS    = 100;

    // One full register setting; weight[0] belongs to plane 0
    typedef struct packed {
        logic [2:0]       mode;
        logic [2:0]       planes;
        logic [1:0]       pick;
        logic [1:0]       part;
        logic [3:0][15:0] weight;
    } t_setting;

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;
    logic                 in_valid  = 1'b0;
    t_in_data             in_data   = '0;
    logic                 out_stall = 1'b0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    t_out_data            o_out_data;

    int mismatches;
    int outstanding;
    int hold_req    = 0;
    int hold_seen   = 0;
    int recv_left   = 0;
    int idle_cycles = 0;

    color_planes_to_scalar_pixel_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (o_out_data)
    );

    reduced_pixel_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .i_in_stall    (o_in_stall),
        .i_in_data     (in_data),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (out_stall),
        .i_out_data    (o_out_data),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Gap length: mostly none or short, now and then long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 50);
    endfunction

    function automatic logic [15:0] rand_sample();
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'($urandom_range(0, 3));
            3:       return 16'hFFFF - 16'($urandom_range(0, 3));
            default: return 16'($urandom);
        endcase
    endfunction

    // Random pixel; copied planes make max/min ties and gray pixels common
    function automatic t_in_data rand_pixel();
        logic [3:0][15:0] s;
        for (int k = 0; k < 4; k++)
            s[k] = rand_sample();
        if ($urandom_range(0, 3) == 0)
            s[$urandom_range(0, 3)] = s[$urandom_range(0, 3)];
        if ($urandom_range(0, 15) == 0)
            s = {4{s[0]}};
        return {s[0], s[1], s[2], s[3]};
    endfunction

    function automatic t_in_data pix(input logic [15:0] p0, input logic [15:0] p1,
                                     input logic [15:0] p2, input logic [15:0] p3);
        return {p0, p1, p2, p3};
    endfunction

    // w is {weight_3, weight_2, weight_1, weight_0}
    function automatic t_setting setting(input logic [2:0] m, input logic [2:0] n,
                                         input logic [1:0] pk, input logic [1:0] pt,
                                         input logic [3:0][15:0] w);
        t_setting st;
        st.mode   = m;
        st.planes = n;
        st.pick   = pk;
        st.part   = pt;
        st.weight = w;
        return st;
    endfunction

    function automatic t_setting rand_setting(input logic [2:0] m);
        t_setting st;
        st.mode = m;
        case ($urandom_range(0, 9))
            0:       st.planes = 3'd0;
            1:       st.planes = 3'($urandom_range(5, 7));
            2, 3:    st.planes = 3'($urandom_range(1, 2));
            default: st.planes = 3'($urandom_range(3, 4));
        endcase
        st.pick = 2'($urandom);
        st.part = 2'($urandom);
        for (int k = 0; k < 4; k++) begin
            case ($urandom_range(0, 5))
                0:       st.weight[k] = 16'h8000;
                1:       st.weight[k] = 16'h7FFF;
                2:       st.weight[k] = 16'h0000;
                default: st.weight[k] = 16'($urandom);
            endcase
        end
        return st;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    // Write all eight registers; junk fills the unused upper bits
    task automatic apply_setting(input t_setting st, input bit junk);
        logic [15:0] fill;
        fill = junk ? 16'($urandom) : 16'd0;
        write_reg(REG_MODE,     {fill[15:3], st.mode});
        write_reg(REG_PLANES,   {fill[15:3], st.planes});
        write_reg(REG_PICK,     {fill[15:2], st.pick});
        write_reg(REG_HSV_PART, {fill[15:2], st.part});
        write_reg(REG_WEIGHT_0, st.weight[0]);
        write_reg(REG_WEIGHT_1, st.weight[1]);
        write_reg(REG_WEIGHT_2, st.weight[2]);
        write_reg(REG_WEIGHT_3, st.weight[3]);
        cfg_we <= 1'b0;
    endtask

    // Offer one pixel, optionally after a random gap, and wait until taken
    task automatic send_pixel(input t_in_data px, input bit gaps);
        int n;
        n = gaps ? idle_len() : 0;
        if (n != 0) begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= px;
        do @(posedge clk); while (o_in_stall);
    endtask

    // Stop offering and wait for every pending result
    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    task automatic directed(input t_setting st, input t_in_data px);
        wait_drained();
        apply_setting(st, 1'b0);
        send_pixel(px, 1'b0);
    endtask

    // Receiver: random stall and free stretches, a long hold on request
    always @(posedge clk) begin : receiver
        int n;
        if (hold_seen != hold_req) begin
            hold_seen <= hold_req;
            out_stall <= 1'b1;
            recv_left <= LONG_HOLD;
        end else if (recv_left != 0) begin
            recv_left <= recv_left - 1;
        end else if (out_stall) begin
            out_stall <= 1'b0;
            recv_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(0, 4);
        end else begin
            n = idle_len();
            out_stall <= (n != 0);
            recv_left <= n;
        end
    end

    // Watchdog on cycles with no accepted pixel and no taken result
    always @(posedge clk) begin
        if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Stimulus
    initial begin
        t_setting st;
        bit       steady;
        int       count;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: luminance over three planes, then luminance on two planes
        send_pixel(pix(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF), 1'b0);
        send_pixel(pix(16'h0000, 16'h0000, 16'h0000, 16'h0000), 1'b0);
        directed(setting(MODE_LUMA, 3'd2, 2'd0, HSV_VALUE, '0),
                 pix(16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0));

        // pick: last plane, then a plane beyond the count
        directed(setting(MODE_PICK, 3'd4, 2'd3, HSV_VALUE, '0),
                 pix(16'h0001, 16'h0002, 16'h0003, 16'hFFFF));
        directed(setting(MODE_PICK, 3'd2, 2'd2, HSV_VALUE, '0),
                 pix(16'h0001, 16'h0002, 16'h0003, 16'h0004));

        // weighted: extreme weights, oversized count, weights past the count
        directed(setting(MODE_WEIGHTED, 3'd4, 2'd0, HSV_VALUE,
                         {16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000}),
                 pix(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        directed(setting(MODE_WEIGHTED, 3'd7, 2'd0, HSV_VALUE, {4{16'h8000}}),
                 pix(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        directed(setting(MODE_WEIGHTED, 3'd1, 2'd0, HSV_VALUE,
                         {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h1000}),
                 pix(16'h8000, 16'hFFFF, 16'hFFFF, 16'hFFFF));

        // mean with rounding
        directed(setting(MODE_MEAN, 3'd3, 2'd0, HSV_VALUE, '0),
                 pix(16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF));
        directed(setting(MODE_MEAN, 3'd4, 2'd0, HSV_VALUE, '0),
                 pix(16'h0001, 16'h0001, 16'h0000, 16'h0000));

        // max and min, oversized count and a single plane
        directed(setting(MODE_MAX, 3'd7, 2'd0, HSV_VALUE, '0),
                 pix(16'h0005, 16'h0007, 16'h0003, 16'hFFFF));
        directed(setting(MODE_MIN, 3'd4, 2'd0, HSV_VALUE, '0),
                 pix(16'hFFFF, 16'h8000, 16'hFFFF, 16'h0001));
        directed(setting(MODE_MIN, 3'd1, 2'd0, HSV_VALUE, '0),
                 pix(16'h0009, 16'h0000, 16'h0000, 16'h0000));

        // hsv: value, saturation incl. black, hue wrap, ties, gray, reserved part
        directed(setting(MODE_HSV, 3'd3, 2'd0, HSV_VALUE, '0),
                 pix(16'h1000, 16'hF000, 16'h0000, 16'hFFFF));
        directed(setting(MODE_HSV, 3'd3, 2'd0, HSV_SAT, '0),
                 pix(16'h0000, 16'h0000, 16'h0000, 16'hFFFF));
        directed(setting(MODE_HSV, 3'd3, 2'd0, HSV_SAT, '0),
                 pix(16'hFFFF, 16'h8000, 16'h0000, 16'h0000));
        directed(setting(MODE_HSV, 3'd3, 2'd0, HSV_HUE, '0),
                 pix(16'hFFFF, 16'h0000, 16'h8000, 16'h0000));
        directed(setting(MODE_HSV, 3'd3, 2'd0, HSV_HUE, '0),
                 pix(16'hC000, 16'hC000, 16'h1000, 16'h0000));
        directed(setting(MODE_HSV, 3'd3, 2'd0, HSV_HUE, '0),
                 pix(16'h0100, 16'hF000, 16'h5000, 16'h0000));
        directed(setting(MODE_HSV, 3'd3, 2'd0, HSV_HUE, '0),
                 pix(16'h0000, 16'h0001, 16'hFFFF, 16'h0000));
        directed(setting(MODE_HSV, 3'd4, 2'd0, HSV_HUE, '0),
                 pix(16'h7777, 16'h7777, 16'h7777, 16'h0000));
        directed(setting(MODE_HSV, 3'd3, 2'd0, HSV_PART_RSVD, '0),
                 pix(16'h2000, 16'hFFFF, 16'h4000, 16'h0000));

        // errors: hsv on two planes, reserved mode, no planes
        directed(setting(MODE_HSV, 3'd2, 2'd0, HSV_VALUE, '0),
                 pix(16'hFFFF, 16'h0001, 16'h0002, 16'h0003));
        directed(setting(MODE_RSVD, 3'd4, 2'd0, HSV_VALUE, '0),
                 pix(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        directed(setting(MODE_PICK, 3'd0, 2'd0, HSV_VALUE, '0),
                 pix(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));

        // random phases, one setting each, every mode twice
        for (int phase = 0; phase < PHASES; phase++) begin
            st = rand_setting(3'(phase % 8));
            wait_drained();
            apply_setting(st, 1'b1);
            steady = (phase == 4) || (phase == 12);
            count  = steady ? PRESS_ITEMS : PHASE_ITEMS;
            // receiver holds off while pixels keep coming back to back
            if (steady)
                hold_req <= hold_req + 1;
            for (int n = 0; n < count; n++)
                send_pixel(rand_pixel(), !(steady || phase % 5 == 2));
        end

        wait_drained();
        repeat (40) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
